// ===== hw/rtl/pcre_pkg.sv =====
// pcre_pkg: shared types, constants and arithmetic helpers of the pixel run encoder
// no dependencies; imported by every module of the block
package pcre_pkg;

  // field and register widths
  localparam int unsigned ChanW   = 8;
  localparam int unsigned AlphaW  = 8;
  localparam int unsigned SideW   = 13;
  localparam int unsigned ColW    = 12;
  localparam int unsigned StepW   = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned NumChan = 3;

  // largest image side, counters wrap below it
  localparam logic [SideW-1:0] MaxSide = SideW'(4096);

  // default queue depth between the color pipeline and the run tracker
  localparam int unsigned FifoDepthDef = 16;

  // quantizer divider layout: 9 numerator bits, 3 bits per stage
  localparam int unsigned NumW         = 9;
  localparam int unsigned DivBitsStage = 3;
  localparam int unsigned DivStages    = 3;

  // register indexes of the configuration port
  localparam logic [CfgIdxW-1:0] CfgImageWidth  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgImageHeight = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgQuantStep   = CfgIdxW'(2);

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
  } rgb_t;

  localparam rgb_t White = '{red: 8'hFF, green: 8'hFF, blue: 8'hFF};

  // one finished color entering the queue
  typedef struct packed {
    logic valid;
    rgb_t color;
  } push_t;

  // head of the queue as seen by the run tracker
  typedef struct packed {
    logic avail;
    rgb_t color;
  } head_t;

  // one run going out
  typedef struct packed {
    rgb_t             color;
    logic [ColW-1:0]  x_start;
    logic [SideW-1:0] x_end;
    logic [ColW-1:0]  row;
  } run_t;

  // floor(x / 255) for 16-bit x up to 65279, where the quotient fits the 8-bit result
  function automatic logic [ChanW-1:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = 17'(x) + 17'(x[15:8]) + 17'd1;
    return t[15:8];
  endfunction

  // one restoring division step: shift in a numerator bit, subtract if it fits
  function automatic logic [StepW:0] div_step(input logic [StepW-1:0] rem,
                                              input logic             nbit,
                                              input logic [StepW-1:0] d);
    logic [StepW:0] t;
    logic [StepW:0] s;
    t = {rem, nbit};
    s = t - {1'b0, d};
    if (t >= {1'b0, d}) begin
      return {s[StepW-1:0], 1'b1};
    end
    return {t[StepW-1:0], 1'b0};
  endfunction

endpackage

// ===== hw/rtl/pcre_front.sv =====
// pcre_front: color pipeline, composites each pixel over white and quantizes it
// depends on pcre_pkg; runs without stalls, the queue reserves room for every pixel
module pcre_front import pcre_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [ChanW-1:0]  pixel_red_i,
  input  logic [ChanW-1:0]  pixel_green_i,
  input  logic [ChanW-1:0]  pixel_blue_i,
  input  logic [AlphaW-1:0] pixel_alpha_i,
  input  logic [StepW-1:0]  step_i,
  output push_t             push_o
);

  // stage valids
  logic s1_vld_q, s2_vld_q, s3_vld_q, s7_vld_q;
  logic [DivStages-1:0] dv_vld_q;

  // stage payloads
  logic [NumChan-1:0][ChanW-1:0]  s1_chan_q;
  logic [AlphaW-1:0]              s1_alpha_q;
  logic [NumChan-1:0][15:0]       s2_prod_q;
  logic [15:0]                    s2_bg_q;
  logic [NumChan-1:0][ChanW-1:0]  s3_bl_q;
  logic [NumChan-1:0][NumW-1:0]   dv_num_q  [DivStages];
  logic [NumChan-1:0][NumW-1:0]   dv_quo_q  [DivStages];
  logic [NumChan-1:0][StepW-1:0]  dv_rem_q  [DivStages];
  logic [NumChan-1:0][ChanW-1:0]  dv_bl_q   [DivStages];
  logic [NumChan-1:0][ChanW+StepW-1:0] s7_qp_q;
  logic [NumChan-1:0][ChanW-1:0]  s7_bl_q;

  logic [NumChan-1:0][ChanW-1:0]  in_chan;
  logic [NumChan-1:0][ChanW-1:0]  q_out;
  logic                           pass;

  assign in_chan = {pixel_red_i, pixel_green_i, pixel_blue_i};
  assign pass    = (step_i <= StepW'(1));

  // valid shift line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      dv_vld_q <= '0;
      s7_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= fire_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      dv_vld_q <= {dv_vld_q[DivStages-2:0], s3_vld_q};
      s7_vld_q <= dv_vld_q[DivStages-1];
    end
  end

  // input capture, products, blend over white
  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      s1_chan_q  <= in_chan;
      s1_alpha_q <= pixel_alpha_i;
    end
    for (int ch = 0; ch < NumChan; ch++) begin
      s2_prod_q[ch] <= 16'(s1_chan_q[ch]) * 16'(s1_alpha_q);
      s3_bl_q[ch]   <= div255(s2_prod_q[ch] + s2_bg_q);
    end
    s2_bg_q <= 16'(8'd255 - s1_alpha_q) * 16'd255 + 16'd127;
  end

  // quantizer divider, (blend + step/2) / step, a few bits per stage
  for (genvar k = 0; k < DivStages; k++) begin : g_div
    logic [NumChan-1:0][NumW-1:0]  num_in, num_nx, quo_in, quo_nx;
    logic [NumChan-1:0][StepW-1:0] rem_in, rem_nx;
    logic [NumChan-1:0][ChanW-1:0] bl_in;

    if (k == 0) begin : g_first
      always_comb begin
        for (int ch = 0; ch < NumChan; ch++) begin
          num_in[ch] = NumW'(s3_bl_q[ch]) + NumW'(step_i >> 1);
          quo_in[ch] = '0;
          rem_in[ch] = '0;
          bl_in[ch]  = s3_bl_q[ch];
        end
      end
    end else begin : g_next
      assign num_in = dv_num_q[k-1];
      assign quo_in = dv_quo_q[k-1];
      assign rem_in = dv_rem_q[k-1];
      assign bl_in  = dv_bl_q[k-1];
    end

    always_comb begin
      logic [StepW:0]     r;
      logic [NumW-1:0]    n;
      logic [NumW-1:0]    q;
      logic [StepW-1:0]   rm;
      for (int ch = 0; ch < NumChan; ch++) begin
        n  = num_in[ch];
        q  = quo_in[ch];
        rm = rem_in[ch];
        for (int j = 0; j < DivBitsStage; j++) begin
          r  = div_step(rm, n[NumW-1], step_i);
          rm = r[StepW:1];
          q  = {q[NumW-2:0], r[0]};
          n  = {n[NumW-2:0], 1'b0};
        end
        num_nx[ch] = n;
        quo_nx[ch] = q;
        rem_nx[ch] = rm;
      end
    end

    always_ff @(posedge clk_i) begin
      dv_num_q[k] <= num_nx;
      dv_quo_q[k] <= quo_nx;
      dv_rem_q[k] <= rem_nx;
      dv_bl_q[k]  <= bl_in;
    end
  end

  // back to a multiple of the step
  always_ff @(posedge clk_i) begin
    for (int ch = 0; ch < NumChan; ch++) begin
      s7_qp_q[ch] <= (ChanW+StepW)'(dv_quo_q[DivStages-1][ch][ChanW-1:0])
                   * (ChanW+StepW)'(step_i);
    end
    s7_bl_q <= dv_bl_q[DivStages-1];
  end

  // saturate, or pass the blend through for a step of zero or one
  always_comb begin
    for (int ch = 0; ch < NumChan; ch++) begin
      if (pass) begin
        q_out[ch] = s7_bl_q[ch];
      end else if (s7_qp_q[ch] > (ChanW+StepW)'(255)) begin
        q_out[ch] = 8'hFF;
      end else begin
        q_out[ch] = s7_qp_q[ch][ChanW-1:0];
      end
    end
  end

  assign push_o.valid       = s7_vld_q;
  assign push_o.color.red   = q_out[2];
  assign push_o.color.green = q_out[1];
  assign push_o.color.blue  = q_out[0];

endmodule

// ===== hw/rtl/pcre_fifo.sv =====
// pcre_fifo: color queue between pipeline and run tracker, with a credit count
// depends on pcre_pkg; credits cover words still in the pipeline so it never overflows
module pcre_fifo import pcre_pkg::*; #(
  parameter int unsigned Depth = FifoDepthDef
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  reserve_i,
  input  push_t push_i,
  input  logic  pop_i,
  output logic  full_o,
  output head_t head_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  rgb_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] used_q, credit_q;

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i.valid) begin
      mem_q[wr_ptr_q] <= push_i.color;
    end
  end

  // pointers and counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      used_q   <= '0;
      credit_q <= '0;
    end else begin
      if (push_i.valid) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      used_q   <= used_q + CntW'(push_i.valid) - CntW'(pop_i);
      credit_q <= credit_q + CntW'(reserve_i) - CntW'(pop_i);
    end
  end

  assign full_o       = (credit_q >= CntW'(Depth));
  assign head_o.avail = (used_q != '0);
  assign head_o.color = mem_q[rd_ptr_q];

endmodule

// ===== hw/rtl/pcre_back.sv =====
// pcre_back: run tracker, follows column and row and emits finished non-white runs
// depends on pcre_pkg; pops one color per word from pcre_fifo
module pcre_back import pcre_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  head_t            head_i,
  input  logic [SideW-1:0] width_i,
  input  logic [SideW-1:0] height_i,
  input  logic             out_stall_i,
  output logic             pop_o,
  output logic             out_valid_o,
  output run_t             out_run_o,
  output logic             out_last_o
);

  // run state
  rgb_t            held_q;
  logic [ColW-1:0] run_begin_q, col_q, row_q;

  // output register and second pending run
  logic out_vld_q, out_last_q, pend_q;
  run_t out_q, pend_run_q;

  logic             slot_free;
  logic             first, change, row_end, emit_a, emit_b;
  rgb_t             held_nx;
  logic [ColW-1:0]  rb_nx;
  logic [SideW-1:0] next_col, next_row;
  run_t             run_a, run_b;

  assign slot_free = !out_vld_q || !out_stall_i;
  assign pop_o     = head_i.avail && slot_free && !pend_q;

  // classify the incoming color against the open run
  always_comb begin
    first    = (col_q == '0);
    change   = !first && (head_i.color != held_q);
    emit_a   = change && (held_q != White);
    held_nx  = (first || change) ? head_i.color : held_q;
    rb_nx    = first ? '0 : (change ? col_q : run_begin_q);
    next_col = SideW'(col_q) + SideW'(1);
    next_row = SideW'(row_q) + SideW'(1);
    row_end  = (next_col >= width_i);
    emit_b   = row_end && (held_nx != White);

    run_a.color   = held_q;
    run_a.x_start = run_begin_q;
    run_a.x_end   = SideW'(col_q);
    run_a.row     = row_q;

    run_b.color   = held_nx;
    run_b.x_start = rb_nx;
    run_b.x_end   = next_col;
    run_b.row     = row_q;
  end

  // state update and output staging
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      run_begin_q <= '0;
      col_q       <= '0;
      row_q       <= '0;
      out_vld_q   <= 1'b0;
      out_last_q  <= 1'b0;
      out_q       <= '0;
      pend_q      <= 1'b0;
      pend_run_q  <= '0;
    end else begin
      if (pend_q && slot_free) begin
        // second run of the previous word
        out_q      <= pend_run_q;
        out_last_q <= 1'b1;
        out_vld_q  <= 1'b1;
        pend_q     <= 1'b0;
      end else if (pop_o) begin
        held_q <= held_nx;
        if (row_end) begin
          col_q       <= '0;
          run_begin_q <= '0;
          row_q       <= (next_row >= height_i) ? '0 : next_row[ColW-1:0];
        end else begin
          col_q       <= next_col[ColW-1:0];
          run_begin_q <= rb_nx;
        end
        if (emit_a) begin
          out_q      <= run_a;
          out_last_q <= !emit_b;
          out_vld_q  <= 1'b1;
          pend_q     <= emit_b;
          pend_run_q <= run_b;
        end else if (emit_b) begin
          out_q      <= run_b;
          out_last_q <= 1'b1;
          out_vld_q  <= 1'b1;
        end else begin
          out_vld_q  <= 1'b0;
        end
      end else if (slot_free) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_run_o   = out_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== hw/rtl/pixel_color_run_encoder.sv =====
// pixel_color_run_encoder: one pixel per cycle while in_stall_o is low; a run leaves
// after the pixel that closes it (seven-stage color pipeline, queue, output register).
// A pixel closing two non-white runs holds the run tracker until its second run is staged.
// The queue depth sets how far the pipeline runs ahead of a stalled output.
// Reset clears row, column and run state and sets width, height and step to one.
// depends on pcre_pkg, pcre_front, pcre_fifo, pcre_back
module pixel_color_run_encoder import pcre_pkg::*; #(
  parameter int unsigned FifoDepth = FifoDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ChanW-1:0]   pixel_red_i,
  input  logic [ChanW-1:0]   pixel_green_i,
  input  logic [ChanW-1:0]   pixel_blue_i,
  input  logic [AlphaW-1:0]  pixel_alpha_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [SideW-1:0]   cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ChanW-1:0]   out_red_o,
  output logic [ChanW-1:0]   out_green_o,
  output logic [ChanW-1:0]   out_blue_o,
  output logic [ColW-1:0]    x_start_o,
  output logic [SideW-1:0]   x_end_o,
  output logic [ColW-1:0]    row_index_o,
  output logic               last_of_item_o
);

  logic [SideW-1:0] width_q, height_q, width_c, height_c;
  logic [StepW-1:0] step_q;
  logic             fire, full, pop;
  push_t            push;
  head_t            head;
  run_t             run;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SideW'(1);
      height_q <= SideW'(1);
      step_q   <= StepW'(1);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgImageWidth:  width_q  <= cfg_data_i;
        CfgImageHeight: height_q <= cfg_data_i;
        CfgQuantStep:   step_q   <= cfg_data_i[StepW-1:0];
        default: ;
      endcase
    end
  end

  // sides clamped to one .. MaxSide
  assign width_c  = (width_q == '0) ? SideW'(1) : ((width_q > MaxSide) ? MaxSide : width_q);
  assign height_c = (height_q == '0) ? SideW'(1) : ((height_q > MaxSide) ? MaxSide : height_q);

  assign in_stall_o = full;
  assign fire       = in_valid_i && !full;

  pcre_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .pixel_red_i   (pixel_red_i),
    .pixel_green_i (pixel_green_i),
    .pixel_blue_i  (pixel_blue_i),
    .pixel_alpha_i (pixel_alpha_i),
    .step_i        (step_q),
    .push_o        (push)
  );

  pcre_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .reserve_i (fire),
    .push_i    (push),
    .pop_i     (pop),
    .full_o    (full),
    .head_o    (head)
  );

  pcre_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .width_i     (width_c),
    .height_i    (height_c),
    .out_stall_i (out_stall_i),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_run_o   (run),
    .out_last_o  (last_of_item_o)
  );

  assign out_red_o   = run.color.red;
  assign out_green_o = run.color.green;
  assign out_blue_o  = run.color.blue;
  assign x_start_o   = run.x_start;
  assign x_end_o     = run.x_end;
  assign row_index_o = run.row;

endmodule
